[sv/vrp_pkg.sv]
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared widths, register codes, pipeline word types and divider step.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int VTX_W     = 24;
    localparam int TRIG_W    = 16;
    localparam int SCL_W     = 24;
    localparam int FRAC_TRIG = 14;
    localparam int Q16       = 16;
    localparam int X1_W      = 27;
    localparam int Y2_W      = 30;
    localparam int W_W       = 31;
    localparam int NUM_W     = 56;
    localparam int DEN_W     = 31;
    localparam int RQ_W      = DEN_W + NUM_W;
    localparam int LANES     = 3;
    localparam int QC_W      = 35;
    localparam int DEPTH_W   = 24;
    localparam int PIX_W     = 16;
    localparam int ADDR_W    = 5;

    localparam logic signed [W_W-1:0]   Z_SHIFT   = 31'sd196608;
    localparam logic [DEN_W-1:0]        Q16_DEN   = 31'd65536;

    localparam logic [2:0] REG_ROT_Z_COS   = 3'd0;
    localparam logic [2:0] REG_ROT_Z_SIN   = 3'd1;
    localparam logic [2:0] REG_ROT_X_COS   = 3'd2;
    localparam logic [2:0] REG_ROT_X_SIN   = 3'd3;
    localparam logic [2:0] REG_PROJ_X_SCL  = 3'd4;
    localparam logic [2:0] REG_PROJ_Y_SCL  = 3'd5;
    localparam logic [2:0] REG_PROJ_Z_SCL  = 3'd6;
    localparam logic [2:0] REG_PROJ_Z_OFS  = 3'd7;

    typedef struct packed {
        logic signed [TRIG_W-1:0] rzc;
        logic signed [TRIG_W-1:0] rzs;
        logic signed [TRIG_W-1:0] rxc;
        logic signed [TRIG_W-1:0] rxs;
        logic signed [SCL_W-1:0]  pxs;
        logic signed [SCL_W-1:0]  pys;
        logic signed [SCL_W-1:0]  pzs;
        logic signed [SCL_W-1:0]  pzo;
    } cfg_t;

    typedef struct packed {
        logic signed [X1_W-1:0] x1;
        logic signed [Y2_W-1:0] y2;
        logic signed [W_W-1:0]  w;
    } rot_t;

    // Lane 0 is x, lane 1 is y, lane 2 is depth.
    typedef struct packed {
        logic [LANES-1:0][RQ_W-1:0] rq;
        logic [DEN_W-1:0]           den;
        logic [LANES-1:0]           neg;
        logic                       wz;
    } div_t;

    // One restoring division step: remainder in the top bits, numerator
    // bits shifting out at the top of the low part, quotient bits in below.
    function automatic logic [RQ_W-1:0] div_step(input logic [RQ_W-1:0] rq,
                                                 input logic [DEN_W-1:0] den);
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   d;
        logic [DEN_W-1:0] r;
        t = rq[RQ_W-1:NUM_W-1];
        d = t - {1'b0, den};
        if (d[DEN_W]) begin
            r = t[DEN_W-1:0];
        end else begin
            r = d[DEN_W-1:0];
        end
        return {r, rq[NUM_W-2:0], ~d[DEN_W]};
    endfunction

    function automatic div_t div_stage(input div_t d);
        div_t o;
        o = d;
        for (int i = 0; i < LANES; i++) begin
            o.rq[i] = div_step(d.rq[i], d.den);
        end
        return o;
    endfunction

endpackage

[sv/vrp_rotate.sv]
// ----------------------------------------------------------------------------
// vrp_rotate
// Four-stage rotation about Z then X, followed by the +3.0 z translation.
// ----------------------------------------------------------------------------
module vrp_rotate import vrp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VTX_W-1:0]   vx,
    input  logic [VTX_W-1:0]   vy,
    input  logic [VTX_W-1:0]   vz,
    output logic               out_valid,
    input  logic               out_ready,
    output rot_t               out_data
);

    localparam int NST = 4;
    localparam int P1_W = VTX_W + TRIG_W;
    localparam int P3_W = X1_W + TRIG_W;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] rdy;

    logic signed [P1_W-1:0]  s1_xcz_reg, s1_ysz_reg, s1_xsz_reg, s1_ycz_reg;
    logic signed [VTX_W-1:0] s1_z_reg, s2_z_reg;
    logic signed [X1_W-1:0]  s2_x1_reg, s2_y1_reg, s3_x1_reg;
    logic signed [X1_W-1:0]  s2_x1_next, s2_y1_next;
    logic signed [P3_W-1:0]  s3_ycx_reg, s3_ysx_reg;
    logic signed [P1_W-1:0]  s3_zsx_reg, s3_zcx_reg;
    rot_t                    s4_reg, s4_next;

    logic signed [P1_W:0]    dx, dy;
    logic signed [P3_W:0]    ey, ez;
    logic signed [Y2_W-1:0]  z2;

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next = {v_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (rdy[i]) v_reg[i] <= v_next[i];
            end
        end
    end

    always_comb begin
        dx = s1_xcz_reg - s1_ysz_reg;
        dy = s1_xsz_reg + s1_ycz_reg;
        s2_x1_next = X1_W'(dx >>> FRAC_TRIG);
        s2_y1_next = X1_W'(dy >>> FRAC_TRIG);
        ey = s3_ycx_reg - s3_zsx_reg;
        ez = s3_ysx_reg + s3_zcx_reg;
        z2 = Y2_W'(ez >>> FRAC_TRIG);
        s4_next.x1 = s3_x1_reg;
        s4_next.y2 = Y2_W'(ey >>> FRAC_TRIG);
        s4_next.w  = W_W'(z2) + Z_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_xcz_reg <= $signed(vx) * cfg.rzc;
            s1_ysz_reg <= $signed(vy) * cfg.rzs;
            s1_xsz_reg <= $signed(vx) * cfg.rzs;
            s1_ycz_reg <= $signed(vy) * cfg.rzc;
            s1_z_reg   <= $signed(vz);
        end
        if (rdy[1]) begin
            s2_x1_reg <= s2_x1_next;
            s2_y1_reg <= s2_y1_next;
            s2_z_reg  <= s1_z_reg;
        end
        if (rdy[2]) begin
            s3_ycx_reg <= s2_y1_reg * cfg.rxc;
            s3_zsx_reg <= s2_z_reg * cfg.rxs;
            s3_ysx_reg <= s2_y1_reg * cfg.rxs;
            s3_zcx_reg <= s2_z_reg * cfg.rxc;
            s3_x1_reg  <= s2_x1_reg;
        end
        if (rdy[3]) begin
            s4_reg <= s4_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_data  = s4_reg;

endmodule

[sv/vrp_project.sv]
// ----------------------------------------------------------------------------
// vrp_project
// Two-stage perspective products and sign/magnitude setup for the divider.
// ----------------------------------------------------------------------------
module vrp_project import vrp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  rot_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    localparam int PX_W = X1_W + SCL_W;
    localparam int PY_W = Y2_W + SCL_W;
    localparam int PZ_W = W_W + SCL_W;

    logic [1:0] v_reg;
    logic [1:0] rdy;

    logic signed [PX_W-1:0] s5_px_reg;
    logic signed [PY_W-1:0] s5_py_reg;
    logic signed [PZ_W-1:0] s5_pz_reg;
    logic signed [W_W-1:0]  s5_w_reg;
    div_t                   s6_reg, s6_next;

    logic signed [NUM_W-1:0] num [LANES];
    logic [NUM_W-1:0]        mag [LANES];
    logic                    wneg;

    assign rdy[1] = !v_reg[1] || out_ready;
    assign rdy[0] = !v_reg[0] || rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_comb begin
        num[0] = NUM_W'(s5_px_reg);
        num[1] = NUM_W'(s5_py_reg);
        num[2] = NUM_W'(s5_pz_reg) + (NUM_W'(cfg.pzo) <<< Q16);
        wneg   = s5_w_reg[W_W-1];
        s6_next.wz  = (s5_w_reg == '0);
        s6_next.den = s6_next.wz ? Q16_DEN
                                 : (wneg ? DEN_W'(-s5_w_reg) : DEN_W'(s5_w_reg));
        for (int i = 0; i < LANES; i++) begin
            mag[i] = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
            s6_next.rq[i]  = {{DEN_W{1'b0}}, mag[i]};
            s6_next.neg[i] = num[i][NUM_W-1] ^ wneg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s5_px_reg <= in_data.x1 * cfg.pxs;
            s5_py_reg <= in_data.y2 * cfg.pys;
            s5_pz_reg <= in_data.w * cfg.pzs;
            s5_w_reg  <= in_data.w;
        end
        if (rdy[1]) begin
            s6_reg <= s6_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[1];
    assign out_data  = s6_reg;

endmodule

[sv/vrp_divider.sv]
// ----------------------------------------------------------------------------
// vrp_divider
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
module vrp_divider import vrp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic [NUM_W-1:0] v_reg;
    logic [NUM_W-1:0] v_next;
    logic [NUM_W-1:0] rdy;
    div_t             st_reg [NUM_W];

    always_comb begin
        rdy[NUM_W-1] = !v_reg[NUM_W-1] || out_ready;
        for (int i = NUM_W - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next = {v_reg[NUM_W-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_W; i++) begin
                if (rdy[i]) v_reg[i] <= v_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) st_reg[0] <= div_stage(in_data);
    end

    for (genvar g = 1; g < NUM_W; g++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (rdy[g]) st_reg[g] <= div_stage(st_reg[g-1]);
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NUM_W-1];
    assign out_data  = st_reg[NUM_W-1];

endmodule

[sv/vrp_screen.sv]
// ----------------------------------------------------------------------------
// vrp_screen
// Quotient sign fixup, clamps, pixel mapping and the output register.
// ----------------------------------------------------------------------------
module vrp_screen import vrp_pkg::*; #(
    parameter int SCREEN_WIDTH  = 400,
    parameter int SCREEN_HEIGHT = 172
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  div_t                      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [PIX_W-1:0]   screen_x,
    output logic signed [PIX_W-1:0]   screen_y,
    output logic signed [DEPTH_W-1:0] depth,
    output logic                      w_zero
);

    localparam int SWX_W = $clog2(SCREEN_WIDTH + 1);
    localparam int SWY_W = $clog2(SCREEN_HEIGHT + 1);
    localparam int PXW   = QC_W + SWX_W + 1;
    localparam int PYW   = QC_W + SWY_W + 1;
    localparam int MAP_SH = Q16 + 1;

    localparam logic signed [SWX_W:0] SIZE_X = (SWX_W + 1)'(SCREEN_WIDTH);
    localparam logic signed [SWY_W:0] SIZE_Y = (SWY_W + 1)'(SCREEN_HEIGHT);
    localparam logic signed [NUM_W:0] QC_MAX = (NUM_W + 1)'(1) <<< (QC_W - 2);
    localparam logic signed [NUM_W:0] QC_MIN = -QC_MAX;
    localparam logic signed [NUM_W:0] D_MAX  = (NUM_W + 1)'((1 <<< (DEPTH_W - 1)) - 1);
    localparam logic signed [NUM_W:0] D_MIN  = -D_MAX - (NUM_W + 1)'(1);
    localparam logic signed [QC_W-1:0] ONE_Q = QC_W'(1 <<< Q16);
    localparam logic signed [PXW-1:0] RND_X  = PXW'((1 <<< MAP_SH) - 1);
    localparam logic signed [PYW-1:0] RND_Y  = PYW'((1 <<< MAP_SH) - 1);
    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W - 1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W - 1){1'b0}}};

    logic [2:0] v_reg;
    logic [2:0] rdy;

    logic signed [NUM_W:0]   q [LANES];
    logic signed [QC_W-1:0]  a_qx_reg, a_qy_reg, a_qx_next, a_qy_next;
    logic signed [DEPTH_W-1:0] a_d_reg, a_d_next, b_d_reg;
    logic                    a_wz_reg, b_wz_reg;
    logic signed [PXW-1:0]   b_px_reg;
    logic signed [PYW-1:0]   b_py_reg;
    logic signed [PXW-1:0]   adj_x, sh_x;
    logic signed [PYW-1:0]   adj_y, sh_y;
    logic signed [PIX_W-1:0] c_x_next, c_y_next;
    logic signed [PIX_W-1:0] c_x_reg, c_y_reg;
    logic signed [DEPTH_W-1:0] c_d_reg;
    logic                    c_wz_reg;

    assign rdy[2] = !v_reg[2] || out_ready;
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
        end
    end

    // Truncating quotient; with zero w the divisor was 2^16 and a negative
    // value with a remainder steps down by one to give the floor.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            q[i] = $signed({1'b0, in_data.rq[i][NUM_W-1:0]});
            if (in_data.neg[i]) q[i] = -q[i];
            if (in_data.wz && in_data.neg[i] && (in_data.rq[i][RQ_W-1:NUM_W] != '0)) begin
                q[i] = q[i] - (NUM_W + 1)'(1);
            end
        end
        a_qx_next = (q[0] > QC_MAX) ? QC_W'(QC_MAX) :
                    (q[0] < QC_MIN) ? QC_W'(QC_MIN) : QC_W'(q[0]);
        a_qy_next = (q[1] > QC_MAX) ? QC_W'(QC_MAX) :
                    (q[1] < QC_MIN) ? QC_W'(QC_MIN) : QC_W'(q[1]);
        a_d_next  = (q[2] > D_MAX) ? DEPTH_W'(D_MAX) :
                    (q[2] < D_MIN) ? DEPTH_W'(D_MIN) : DEPTH_W'(q[2]);
    end

    always_comb begin
        adj_x = b_px_reg + (b_px_reg[PXW-1] ? RND_X : '0);
        adj_y = b_py_reg + (b_py_reg[PYW-1] ? RND_Y : '0);
        sh_x  = adj_x >>> MAP_SH;
        sh_y  = adj_y >>> MAP_SH;
        c_x_next = (sh_x > PXW'(PIX_MAX)) ? PIX_MAX :
                   (sh_x < PXW'(PIX_MIN)) ? PIX_MIN : PIX_W'(sh_x);
        c_y_next = (sh_y > PYW'(PIX_MAX)) ? PIX_MAX :
                   (sh_y < PYW'(PIX_MIN)) ? PIX_MIN : PIX_W'(sh_y);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a_qx_reg <= a_qx_next;
            a_qy_reg <= a_qy_next;
            a_d_reg  <= a_d_next;
            a_wz_reg <= in_data.wz;
        end
        if (rdy[1]) begin
            b_px_reg <= (a_qx_reg + ONE_Q) * SIZE_X;
            b_py_reg <= (a_qy_reg + ONE_Q) * SIZE_Y;
            b_d_reg  <= a_d_reg;
            b_wz_reg <= a_wz_reg;
        end
        if (rdy[2]) begin
            c_x_reg  <= c_x_next;
            c_y_reg  <= c_y_next;
            c_d_reg  <= b_d_reg;
            c_wz_reg <= b_wz_reg;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[2];
    assign screen_x  = c_x_reg;
    assign screen_y  = c_y_reg;
    assign depth     = c_d_reg;
    assign w_zero    = c_wz_reg;

endmodule

[sv/vertex_rotate_project.sv]
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Rotates a Q8.16 vertex about Z and X, translates, projects and maps it
// to pixel coordinates with a depth value and a w-zero flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_axis    in         x, y, z (24 bits each, signed Q8.16)
//  m_axis    out        screen_x, screen_y, depth; tuser = w_zero
//  apb       in/out     eight rotation and projection registers
//
// One word enters per cycle while s_tready is high. The pipeline is four
// rotation stages, two projection stages, 56 divider stages (one quotient
// bit each) and three mapping stages ending in the output register. Every
// stage holds a valid bit and advances when it is empty or the next stage
// moves, so a stall on m_tready fills bubbles before s_tready drops. Reset
// clears the valid bits and loads the register defaults.
//
module vertex_rotate_project import vrp_pkg::*; #(
    parameter int SCREEN_WIDTH  = 400,
    parameter int SCREEN_HEIGHT = 172
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [23:0] vertex_x, [47:24] vertex_y, [71:48] vertex_z
    input  logic [71:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [15:0] screen_x, [31:16] screen_y, [55:32] depth
    output logic [55:0]       m_tdata,
    // [0] w_zero
    output logic [0:0]        m_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t        cfg_reg;
    logic [2:0]  reg_idx;

    logic        rot_valid, rot_ready;
    rot_t        rot_data;
    logic        prj_valid, prj_ready;
    div_t        prj_data;
    logic        div_valid, div_ready;
    div_t        div_data;

    logic signed [PIX_W-1:0]   screen_x, screen_y;
    logic signed [DEPTH_W-1:0] depth;
    logic                      w_zero;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register file. Writes land on the access cycle of an APB write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rzc <= 16'sd16384;
            cfg_reg.rzs <= 16'sd0;
            cfg_reg.rxc <= 16'sd16384;
            cfg_reg.rxs <= 16'sd0;
            cfg_reg.pxs <= 24'sd28180;
            cfg_reg.pys <= 24'sd65536;
            cfg_reg.pzs <= 24'sd65543;
            cfg_reg.pzo <= -24'sd6554;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_ROT_Z_COS:  cfg_reg.rzc <= pwdata[TRIG_W-1:0];
                REG_ROT_Z_SIN:  cfg_reg.rzs <= pwdata[TRIG_W-1:0];
                REG_ROT_X_COS:  cfg_reg.rxc <= pwdata[TRIG_W-1:0];
                REG_ROT_X_SIN:  cfg_reg.rxs <= pwdata[TRIG_W-1:0];
                REG_PROJ_X_SCL: cfg_reg.pxs <= pwdata[SCL_W-1:0];
                REG_PROJ_Y_SCL: cfg_reg.pys <= pwdata[SCL_W-1:0];
                REG_PROJ_Z_SCL: cfg_reg.pzs <= pwdata[SCL_W-1:0];
                REG_PROJ_Z_OFS: cfg_reg.pzo <= pwdata[SCL_W-1:0];
            endcase
        end
    end

    // Read data is the raw register bits, zero extended.
    always_comb begin
        unique case (reg_idx)
            REG_ROT_Z_COS:  prdata = 32'(unsigned'(cfg_reg.rzc));
            REG_ROT_Z_SIN:  prdata = 32'(unsigned'(cfg_reg.rzs));
            REG_ROT_X_COS:  prdata = 32'(unsigned'(cfg_reg.rxc));
            REG_ROT_X_SIN:  prdata = 32'(unsigned'(cfg_reg.rxs));
            REG_PROJ_X_SCL: prdata = 32'(unsigned'(cfg_reg.pxs));
            REG_PROJ_Y_SCL: prdata = 32'(unsigned'(cfg_reg.pys));
            REG_PROJ_Z_SCL: prdata = 32'(unsigned'(cfg_reg.pzs));
            REG_PROJ_Z_OFS: prdata = 32'(unsigned'(cfg_reg.pzo));
        endcase
    end

    vrp_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vx        (s_tdata[23:0]),
        .vy        (s_tdata[47:24]),
        .vz        (s_tdata[71:48]),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    vrp_project u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (prj_valid),
        .out_ready (prj_ready),
        .out_data  (prj_data)
    );

    vrp_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prj_valid),
        .in_ready  (prj_ready),
        .in_data   (prj_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    vrp_screen #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_screen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .depth     (depth),
        .w_zero    (w_zero)
    );

    assign m_tdata = {depth, screen_y, screen_x};
    assign m_tuser = w_zero;

endmodule
